### rtl/hsfc_pkg.sv
// Shared types and constants for the half/single float converter.
// No dependencies; imported by hsfc_conv and half_single_float_converter_unit.
package hsfc_pkg;

	typedef enum logic {
		OP_H2S = 1'b0,
		OP_S2H = 1'b1
	} opcode_t;

	localparam logic [31:0] SINGLE_QNAN   = 32'h7fc0_0000;
	localparam logic [15:0] HALF_QNAN     = 16'h7e00;
	localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;
	localparam logic [4:0]  HALF_EXP_MAX  = 5'h1f;
	localparam logic [4:0]  HALF_EXP_SAT  = 5'h1e;
	localparam logic [9:0]  HALF_FRAC_SAT = 10'h3ff;
	// Rebias between formats, largest single exponent that fits a half,
	// and lowest single exponent that still gives a half subnormal
	localparam logic [7:0]  EXP_REBIAS    = 8'd112;
	localparam logic [7:0]  EXP_OVF_LIM   = 8'd142;
	localparam logic [7:0]  EXP_SUB_LOW   = 8'd103;
	localparam logic [7:0]  EXP_SUB_SHIFT = 8'd126;

endpackage

### rtl/hsfc_conv.sv
// Combinational conversion between binary16 and binary32 bit patterns.
// Depends on hsfc_pkg for the opcode type and format constants.
module hsfc_conv import hsfc_pkg::*; (
	input  opcode_t     opcode,
	input  logic [31:0] operand,
	output logic [31:0] converted
);

	logic [31:0] h2s;
	logic [15:0] s2h;

	// half to single
	logic        h_sign;
	logic [4:0]  h_exp;
	logic [9:0]  h_frac;
	logic [3:0]  lead;
	logic [9:0]  h_norm;
	logic [7:0]  h2s_exp;
	logic [22:0] h2s_frac;

	always_comb begin
		h_sign = operand[15];
		h_exp  = operand[14:10];
		h_frac = operand[9:0];
		lead   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_frac[i]) begin
				lead = 4'(i);
			end
		end
		// move the leading one up to bit 9, then drop it
		h_norm   = h_frac << (4'd9 - lead);
		h2s_exp  = 8'd0;
		h2s_frac = 23'd0;
		h2s      = 32'd0;
		if (h_exp == HALF_EXP_MAX) begin
			h2s_exp = SINGLE_EXP_MAX;
			h2s     = {h_sign, h2s_exp, h2s_frac};
			if (h_frac != 10'd0) begin
				h2s = SINGLE_QNAN;
			end
		end else if (h_exp == 5'd0) begin
			if (h_frac != 10'd0) begin
				h2s_exp  = EXP_SUB_LOW + {4'd0, lead};
				h2s_frac = {h_norm[8:0], 14'd0};
			end
			h2s = {h_sign, h2s_exp, h2s_frac};
		end else begin
			h2s_exp  = {3'd0, h_exp} + EXP_REBIAS;
			h2s_frac = {h_frac, 13'd0};
			h2s      = {h_sign, h2s_exp, h2s_frac};
		end
	end

	// single to half, truncating toward zero
	logic        s_sign;
	logic [7:0]  s_exp;
	logic [22:0] s_mant;
	logic [7:0]  sub_shift;
	logic [23:0] sub_val;
	logic [4:0]  s2h_exp;
	logic [9:0]  s2h_frac;

	always_comb begin
		s_sign    = operand[31];
		s_exp     = operand[30:23];
		s_mant    = operand[22:0];
		sub_shift = EXP_SUB_SHIFT - s_exp;
		sub_val   = {1'b1, s_mant} >> sub_shift[4:0];
		s2h_exp   = 5'd0;
		s2h_frac  = 10'd0;
		priority if (s_exp == SINGLE_EXP_MAX) begin
			s2h_exp = HALF_EXP_MAX;
		end else if (s_exp > EXP_OVF_LIM) begin
			s2h_exp  = HALF_EXP_SAT;
			s2h_frac = HALF_FRAC_SAT;
		end else if (s_exp > EXP_REBIAS) begin
			s2h_exp  = 5'(s_exp - EXP_REBIAS);
			s2h_frac = s_mant[22:13];
		end else if (s_exp >= EXP_SUB_LOW) begin
			s2h_frac = sub_val[9:0];
		end else begin
			s2h_frac = 10'd0;
		end
		s2h = {s_sign, s2h_exp, s2h_frac};
		if (s_exp == SINGLE_EXP_MAX && s_mant != 23'd0) begin
			s2h = HALF_QNAN;
		end
	end

	always_comb begin
		unique case (opcode)
			OP_H2S: converted = h2s;
			OP_S2H: converted = {16'd0, s2h};
			default: converted = h2s;
		endcase
	end

endmodule

### rtl/half_single_float_converter_unit.sv
// Top level of the half/single float converter: input register, conversion, result register.
// Depends on hsfc_pkg and hsfc_conv.
//
//  channel  | direction | tdata            | tuser
//  s_axis   | in        | [31:0] operand   | [0] opcode
//  m_axis   | out       | [31:0] converted | -
//
// One item per cycle sustained while m_axis_tready is high; an accepted item is held
// in the input register, then converted into the result register that drives m_axis.
// The rate is set by the single conversion stage between the two registers.
// Reset clears both stage valid flags; no clearing pass.
// A stalled result holds the output register; the input register still fills, and
// s_axis_tready drops only when both registers are occupied and the output is stalled.
module half_single_float_converter_unit import hsfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] operand
	input  logic [0:0]  s_axis_tuser,  // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] converted
);

	logic        valid_s1;
	opcode_t     opcode_s1;
	logic [31:0] operand_s1;
	logic        valid_s2;
	logic [31:0] converted_s2;
	logic [31:0] conv_result;
	logic        adv_s1;

	// stage 1 may move on when the result register is empty or being drained
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1  <= opcode_t'(s_axis_tuser[0]);
			operand_s1 <= s_axis_tdata;
		end
		if (adv_s1 && valid_s1) begin
			converted_s2 <= conv_result;
		end
	end

	hsfc_conv u_conv (
		.opcode    (opcode_s1),
		.operand   (operand_s1),
		.converted (conv_result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = converted_s2;

	// full pipeline behind a stalled output must back-pressure the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while both stages full and output stalled");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted item not held in input register");

	a_s2h_upper: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 && opcode_s1 == OP_S2H |=> m_axis_tdata[31:16] == 16'd0)
		else $error("single to half result has nonzero upper half");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 |=> m_axis_tvalid)
		else $error("item lost between stages");

endmodule
